FILE: src/bilinear_plane_resize_macros.svh
`ifndef BILINEAR_PLANE_RESIZE_MACROS_SVH
`define BILINEAR_PLANE_RESIZE_MACROS_SVH

// same-cycle implication
`define BPR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bilinear_plane_resize: assertion failed");

// next-cycle implication
`define BPR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bilinear_plane_resize: assertion failed");

`endif

FILE: src/bpr_pkg.sv
`default_nettype none

package bpr_pkg;

   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 16;

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
   localparam int ADDR_BITS = COL_BITS + ROW_BITS;
   localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;

   localparam int POS_BITS   = 8;
   localparam int DIM_BITS   = 9;
   localparam int SCALE_BITS = 24;
   localparam int PROD_BITS  = POS_BITS + SCALE_BITS;
   localparam int INT_BITS   = PROD_BITS - FRAC_BITS;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_INTERP = 1'b1;

   typedef enum logic [1:0] {
      REG_SRC_WIDTH  = 2'd0,
      REG_SRC_HEIGHT = 2'd1,
      REG_SCALE_X    = 2'd2,
      REG_SCALE_Y    = 2'd3
   } reg_index_type;

   // bit 0 picks the right column, bit 1 the lower row
   typedef enum logic [1:0] {
      TAP_00 = 2'd0,
      TAP_10 = 2'd1,
      TAP_01 = 2'd2,
      TAP_11 = 2'd3
   } tap_type;

   typedef struct packed {
      logic [DIM_BITS-1:0]   width;
      logic [DIM_BITS-1:0]   height;
      logic [SCALE_BITS-1:0] scale_x;
      logic [SCALE_BITS-1:0] scale_y;
   } cfg_type;

   typedef struct packed {
      logic    wr_mem;
      logic    ld_req;
      logic    ld_clamp;
      logic    rd_en;
      tap_type rd_sel;
      logic    cap_en;
      tap_type cap_sel;
      logic    ld_horiz;
      logic    ld_result;
   } dp_cmd_type;

endpackage

`default_nettype wire

FILE: src/bpr_csr.sv
`default_nettype none

module bpr_csr import bpr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   cfg_type       cfg_ff;
   reg_index_type idx;
   logic          wr_en;

   assign idx    = reg_index_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width   <= DIM_BITS'(MAX_WIDTH);
         cfg_ff.height  <= DIM_BITS'(MAX_HEIGHT);
         cfg_ff.scale_x <= SCALE_BITS'(1 << FRAC_BITS);
         cfg_ff.scale_y <= SCALE_BITS'(1 << FRAC_BITS);
      end else if (wr_en) begin
         case (idx)
            REG_SRC_WIDTH:  cfg_ff.width   <= pwdata[DIM_BITS-1:0];
            REG_SRC_HEIGHT: cfg_ff.height  <= pwdata[DIM_BITS-1:0];
            REG_SCALE_X:    cfg_ff.scale_x <= pwdata[SCALE_BITS-1:0];
            REG_SCALE_Y:    cfg_ff.scale_y <= pwdata[SCALE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_SRC_WIDTH:  prdata = CSR_DATA_BITS'(cfg_ff.width);
         REG_SRC_HEIGHT: prdata = CSR_DATA_BITS'(cfg_ff.height);
         REG_SCALE_X:    prdata = CSR_DATA_BITS'(cfg_ff.scale_x);
         REG_SCALE_Y:    prdata = CSR_DATA_BITS'(cfg_ff.scale_y);
         default:        prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: src/bpr_ctrl.sv
`default_nettype none

module bpr_ctrl import bpr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       opcode,
   output logic       busy,
   output dp_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_RD00,
      ST_RD10,
      ST_RD01,
      ST_RD11,
      ST_TAP3,
      ST_HORIZ,
      ST_VERT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      accept;

   assign accept = start & ~busy_ff;
   assign busy   = busy_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept && opcode == OP_INTERP) state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_RD00;
         ST_RD00:  state_in = ST_RD10;
         ST_RD10:  state_in = ST_RD01;
         ST_RD01:  state_in = ST_RD11;
         ST_RD11:  state_in = ST_TAP3;
         ST_TAP3:  state_in = ST_HORIZ;
         ST_HORIZ: state_in = ST_VERT;
         ST_VERT:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.rd_sel    = TAP_00;
      cmd.cap_sel   = TAP_00;
      cmd.wr_mem    = accept && (opcode == OP_WRITE);
      cmd.ld_req    = accept && (opcode == OP_INTERP);
      case (state_ff)
         ST_CLAMP: cmd.ld_clamp = 1'b1;
         ST_RD00: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = TAP_00;
         end
         ST_RD10: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = TAP_10;
            cmd.cap_en  = 1'b1;
            cmd.cap_sel = TAP_00;
         end
         ST_RD01: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = TAP_01;
            cmd.cap_en  = 1'b1;
            cmd.cap_sel = TAP_10;
         end
         ST_RD11: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = TAP_11;
            cmd.cap_en  = 1'b1;
            cmd.cap_sel = TAP_01;
         end
         ST_TAP3: begin
            cmd.cap_en  = 1'b1;
            cmd.cap_sel = TAP_11;
         end
         ST_HORIZ: cmd.ld_horiz  = 1'b1;
         ST_VERT:  cmd.ld_result = 1'b1;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

FILE: src/bpr_dp.sv
`default_nettype none

module bpr_dp import bpr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   input  cfg_type                cfg,
   input  logic [POS_BITS-1:0]    pos_x,
   input  logic [POS_BITS-1:0]    pos_y,
   input  logic [SAMPLE_BITS-1:0] sample,
   output logic                   rsp_valid,
   output logic [SAMPLE_BITS-1:0] pixel_value
);

   localparam int TOP_BITS = SAMPLE_BITS + FRAC_BITS;
   localparam int ACC_BITS = SAMPLE_BITS + 2 * FRAC_BITS;

   logic [SAMPLE_BITS-1:0] plane_mem [DEPTH];
   logic [SAMPLE_BITS-1:0] rdata_ff;
   logic [SAMPLE_BITS-1:0] v_ff [4];

   logic [PROD_BITS-1:0]   sx_ff, sy_ff;
   logic [COL_BITS-1:0]    x0_ff, x1_ff, last_col;
   logic [ROW_BITS-1:0]    y0_ff, y1_ff, last_row;
   logic [FRAC_BITS-1:0]   fx_ff, fy_ff;
   logic [TOP_BITS-1:0]    top_ff, bot_ff;
   logic [SAMPLE_BITS-1:0] pixel_ff;
   logic                   valid_ff;

   logic [INT_BITS-1:0]    ix, iy;
   logic                   x_over, y_over;
   logic [COL_BITS-1:0]    x0_in;
   logic [ROW_BITS-1:0]    y0_in;
   logic                   wr_ok;
   logic [ADDR_BITS-1:0]   wr_addr, rd_addr;

   logic signed [SAMPLE_BITS:0]   dtop, dbot;
   logic signed [TOP_BITS+1:0]    top_full, bot_full;
   logic signed [TOP_BITS:0]      dv;
   logic signed [ACC_BITS+1:0]    acc;

   // plane dimensions as last valid index
   assign last_col = (cfg.width == '0) ? '0 :
                     (32'(cfg.width) > MAX_WIDTH) ? COL_BITS'(MAX_WIDTH - 1) :
                     COL_BITS'(cfg.width - 1'b1);
   assign last_row = (cfg.height == '0) ? '0 :
                     (32'(cfg.height) > MAX_HEIGHT) ? ROW_BITS'(MAX_HEIGHT - 1) :
                     ROW_BITS'(cfg.height - 1'b1);

   assign ix     = sx_ff[PROD_BITS-1:FRAC_BITS];
   assign iy     = sy_ff[PROD_BITS-1:FRAC_BITS];
   assign x_over = 32'(ix) > 32'(last_col);
   assign y_over = 32'(iy) > 32'(last_row);
   assign x0_in  = x_over ? last_col : COL_BITS'(ix);
   assign y0_in  = y_over ? last_row : ROW_BITS'(iy);

   assign wr_ok   = (32'(pos_x) < MAX_WIDTH) && (32'(pos_y) < MAX_HEIGHT);
   assign wr_addr = {ROW_BITS'(pos_y), COL_BITS'(pos_x)};
   assign rd_addr = {cmd.rd_sel[1] ? y1_ff : y0_ff, cmd.rd_sel[0] ? x1_ff : x0_ff};

   always_ff @(posedge clock) begin
      if (cmd.wr_mem && wr_ok) begin
         plane_mem[wr_addr] <= sample;
      end else if (cmd.rd_en) begin
         rdata_ff <= plane_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_req) begin
         sx_ff <= PROD_BITS'(pos_x) * PROD_BITS'(cfg.scale_x);
         sy_ff <= PROD_BITS'(pos_y) * PROD_BITS'(cfg.scale_y);
      end
      if (cmd.ld_clamp) begin
         x0_ff <= x0_in;
         x1_ff <= (x0_in == last_col) ? last_col : x0_in + 1'b1;
         fx_ff <= x_over ? '0 : sx_ff[FRAC_BITS-1:0];
         y0_ff <= y0_in;
         y1_ff <= (y0_in == last_row) ? last_row : y0_in + 1'b1;
         fy_ff <= y_over ? '0 : sy_ff[FRAC_BITS-1:0];
      end
      if (cmd.cap_en) begin
         v_ff[cmd.cap_sel] <= rdata_ff;
      end
      if (cmd.ld_horiz) begin
         top_ff <= top_full[TOP_BITS-1:0];
         bot_ff <= bot_full[TOP_BITS-1:0];
      end
      if (cmd.ld_result) begin
         pixel_ff <= acc[ACC_BITS-1:2*FRAC_BITS];
      end
   end

   // v0 * 2^F + f * (v1 - v0), exact and never negative
   assign dtop = $signed({1'b0, v_ff[TAP_10]}) - $signed({1'b0, v_ff[TAP_00]});
   assign dbot = $signed({1'b0, v_ff[TAP_11]}) - $signed({1'b0, v_ff[TAP_01]});
   assign top_full = $signed({2'b00, v_ff[TAP_00], {FRAC_BITS{1'b0}}})
                   + $signed({1'b0, fx_ff}) * dtop;
   assign bot_full = $signed({2'b00, v_ff[TAP_01], {FRAC_BITS{1'b0}}})
                   + $signed({1'b0, fx_ff}) * dbot;

   assign dv  = $signed({1'b0, bot_ff}) - $signed({1'b0, top_ff});
   assign acc = $signed({2'b00, top_ff, {FRAC_BITS{1'b0}}})
              + $signed({1'b0, fy_ff}) * dv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.ld_result;
      end
   end

   assign rsp_valid   = valid_ff;
   assign pixel_value = pixel_ff;

endmodule

`default_nettype wire

FILE: src/bilinear_plane_resize.sv
`default_nettype none

// Bilinear plane resampler. An item is taken at a clock edge with start high and busy low.
// A write item stores req_sample at (req_pos_x, req_pos_y) at that edge and busy stays low,
// so writes can stream one per cycle. A request item raises busy until its result shows on
// rsp_pixel_value with rsp_valid high for exactly one cycle; busy falls in that same cycle,
// so a new item can be taken then. A request passes the coordinate multiply, the clamp,
// four tap reads through the single port of the plane memory, and the horizontal and
// vertical multiply stages. Results cannot be held off: the receiver must take rsp_valid
// beats as they come. Samples must be written before a request reads them. The user writes
// configuration through the APB port while busy is low; the block does not enforce this.

module bilinear_plane_resize import bpr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_opcode,
   input  logic [POS_BITS-1:0]      req_pos_x,
   input  logic [POS_BITS-1:0]      req_pos_y,
   input  logic [SAMPLE_BITS-1:0]   req_sample,
   output logic                     rsp_valid,
   output logic [SAMPLE_BITS-1:0]   rsp_pixel_value,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   cfg_type    cfg;
   dp_cmd_type cmd;

   bpr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bpr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .opcode (req_opcode),
      .busy   (busy),
      .cmd    (cmd)
   );

   bpr_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cfg         (cfg),
      .pos_x       (req_pos_x),
      .pos_y       (req_pos_y),
      .sample      (req_sample),
      .rsp_valid   (rsp_valid),
      .pixel_value (rsp_pixel_value)
   );

endmodule

`default_nettype wire

FILE: src/bpr_checker.sv
`default_nettype none

`include "bilinear_plane_resize_macros.svh"

module bpr_checker import bpr_pkg::*; (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_opcode,
   input logic rsp_valid
);

   `BPR_ASSERT_NEXT(a_req_busy, start && !busy && req_opcode == OP_INTERP, busy)
   `BPR_ASSERT_NEXT(a_wr_quiet, start && !busy && req_opcode == OP_WRITE, !busy && !rsp_valid)
   `BPR_ASSERT_NOW(a_rsp_idle, rsp_valid, !busy)
   `BPR_ASSERT_NOW(a_done_rsp, $fell(busy), rsp_valid)
   `BPR_ASSERT_NEXT(a_one_beat, rsp_valid, !rsp_valid)

endmodule

bind bilinear_plane_resize bpr_checker u_bpr_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_opcode (req_opcode),
   .rsp_valid  (rsp_valid)
);

`default_nettype wire
